// ===== src/abae_pkg.sv =====
`default_nettype none
package abae_pkg;

  localparam int MAX_PAYLOAD  = 1020;
  localparam int HEADER_BYTES = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam int LEN_W  = 10;
  localparam int FLEN_W = 11;
  localparam int ATT_W  = 4;
  localparam int CODE_W = 8;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_RECV    = 2'd1,
    OP_FRAME   = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_DATA   = 2'd0,
    ACT_ACK    = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_NONE        = 3'd0,
    ST_SEND_DONE   = 3'd1,
    ST_DELIVERED   = 3'd2,
    ST_PEER_QUIT   = 3'd3,
    ST_SEND_FAILED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ATTEMPTS = 2'd0,
    CFG_DATA_TYPE    = 2'd1,
    CFG_ACK_TYPE     = 2'd2,
    CFG_RESET_TYPE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    action_t          action;
    logic             seqno;
    logic             ackno;
    logic [LEN_W-1:0] len;
    status_t          status;
  } result_t;

  // One event's worth of results: res1 only meaningful when two is set
  typedef struct packed {
    result_t res0;
    result_t res1;
    logic    two;
  } job_t;

endpackage
`default_nettype wire

// ===== src/abae_front.sv =====
`default_nettype none
module abae_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [abae_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [abae_pkg::CODE_W-1:0]          cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_operation,
  input  wire logic [abae_pkg::LEN_W-1:0]           in_request_len,
  input  wire logic [7:0]                           in_frame_type,
  input  wire logic [7:0]                           in_frame_seqno,
  input  wire logic [7:0]                           in_frame_ackno,
  input  wire logic [7:0]                           in_frame_mbz,
  input  wire logic [abae_pkg::FLEN_W-1:0]          in_frame_len,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output abae_pkg::job_t                            q_push_job
);

  localparam logic [abae_pkg::LEN_W-1:0] MaxLen =
    abae_pkg::LEN_W'(abae_pkg::MAX_PAYLOAD);
  localparam logic [abae_pkg::FLEN_W-1:0] MaxLenWide =
    abae_pkg::FLEN_W'(abae_pkg::MAX_PAYLOAD);
  localparam logic [abae_pkg::FLEN_W-1:0] HdrLen =
    abae_pkg::FLEN_W'(abae_pkg::HEADER_BYTES);

  logic [abae_pkg::ATT_W-1:0]  max_att_r;
  logic [abae_pkg::CODE_W-1:0] data_code_r, ack_code_r, reset_code_r;

  logic                        send_bit_r, send_bit_nxt;
  logic                        expect_bit_r, expect_bit_nxt;
  abae_pkg::mode_t             mode_r, mode_nxt;
  logic [abae_pkg::ATT_W-1:0]  att_r, att_nxt;
  logic [abae_pkg::LEN_W-1:0]  held_len_r, held_len_nxt;
  logic [abae_pkg::LEN_W-1:0]  recv_limit_r, recv_limit_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [7:0]                  pend_seq_r, pend_seq_nxt;
  logic [abae_pkg::LEN_W-1:0]  pend_len_r, pend_len_nxt;

  abae_pkg::op_t               op;
  logic                        accept;
  logic                        short_frame;
  logic [abae_pkg::FLEN_W-1:0] body_len;
  logic [abae_pkg::LEN_W-1:0]  plen;
  logic [abae_pkg::LEN_W-1:0]  req_clamped;
  logic                        retry_ok;
  abae_pkg::result_t           retry_res;
  abae_pkg::result_t           res0, res1;
  logic                        res_any, res_two, do_retry;

  function automatic abae_pkg::result_t mk_data(input logic seq,
                                                input logic [abae_pkg::LEN_W-1:0] len);
    abae_pkg::result_t r;
    r.action = abae_pkg::ACT_DATA;
    r.seqno  = seq;
    r.ackno  = 1'b0;
    r.len    = len;
    r.status = abae_pkg::ST_NONE;
    return r;
  endfunction

  function automatic abae_pkg::result_t mk_ack(input logic seq);
    abae_pkg::result_t r;
    r.action = abae_pkg::ACT_ACK;
    r.seqno  = 1'b0;
    r.ackno  = ~seq;
    r.len    = '0;
    r.status = abae_pkg::ST_NONE;
    return r;
  endfunction

  function automatic abae_pkg::result_t mk_finish(input logic [abae_pkg::LEN_W-1:0] len,
                                                  input abae_pkg::status_t st);
    abae_pkg::result_t r;
    r.action = abae_pkg::ACT_FINISH;
    r.seqno  = 1'b0;
    r.ackno  = 1'b0;
    r.len    = len;
    r.status = st;
    return r;
  endfunction

  assign op       = abae_pkg::op_t'(in_operation);
  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  assign short_frame = in_frame_len < HdrLen;
  assign body_len    = in_frame_len - HdrLen;
  assign plen        = short_frame ? '0 :
                       (body_len > MaxLenWide) ? MaxLen : body_len[abae_pkg::LEN_W-1:0];
  assign req_clamped = (in_request_len > MaxLen) ? MaxLen : in_request_len;

  // max_attempts of zero never passes this compare, so it behaves as one
  assign retry_ok  = att_r < max_att_r;
  assign retry_res = retry_ok ? mk_data(send_bit_r, held_len_r)
                              : mk_finish('0, abae_pkg::ST_SEND_FAILED);

  always_comb begin
    send_bit_nxt   = send_bit_r;
    expect_bit_nxt = expect_bit_r;
    mode_nxt       = mode_r;
    att_nxt        = att_r;
    held_len_nxt   = held_len_r;
    recv_limit_nxt = recv_limit_r;
    pend_valid_nxt = pend_valid_r;
    pend_seq_nxt   = pend_seq_r;
    pend_len_nxt   = pend_len_r;
    res0     = '0;
    res1     = '0;
    res_any  = 1'b0;
    res_two  = 1'b0;
    do_retry = 1'b0;

    case (op)
      abae_pkg::OP_SEND: begin
        if (mode_r == abae_pkg::MODE_IDLE) begin
          res_any = 1'b1;
          if (in_request_len == '0) begin
            res0 = mk_finish('0, abae_pkg::ST_SEND_FAILED);
          end else begin
            held_len_nxt = req_clamped;
            att_nxt      = abae_pkg::ATT_W'(1);
            mode_nxt     = abae_pkg::MODE_SEND;
            res0         = mk_data(send_bit_r, req_clamped);
          end
        end
      end
      abae_pkg::OP_RECV: begin
        if (mode_r == abae_pkg::MODE_IDLE) begin
          if (in_request_len == '0) begin
            res_any = 1'b1;
            res0    = mk_finish('0, abae_pkg::ST_NONE);
          end else begin
            recv_limit_nxt = in_request_len;
            if (pend_valid_r) begin
              pend_valid_nxt = 1'b0;
              res_any        = 1'b1;
              res0           = mk_ack(pend_seq_r[0]);
              if (pend_seq_r == {7'd0, expect_bit_r}) begin
                res_two        = 1'b1;
                res1           = mk_finish((pend_len_r < in_request_len) ?
                                           pend_len_r : in_request_len,
                                           abae_pkg::ST_DELIVERED);
                expect_bit_nxt = ~expect_bit_r;
              end else begin
                mode_nxt = abae_pkg::MODE_RECV;
              end
            end else begin
              mode_nxt = abae_pkg::MODE_RECV;
            end
          end
        end
      end
      default: begin
        if (mode_r == abae_pkg::MODE_SEND) begin
          res_any = 1'b1;
          if (op == abae_pkg::OP_TIMEOUT || short_frame) begin
            res0     = retry_res;
            do_retry = 1'b1;
          end else if (in_frame_type == reset_code_r) begin
            mode_nxt = abae_pkg::MODE_IDLE;
            res0     = mk_finish('0, abae_pkg::ST_PEER_QUIT);
          end else if (in_frame_type == ack_code_r) begin
            if (in_frame_ackno == {7'd0, ~send_bit_r}) begin
              send_bit_nxt = ~send_bit_r;
              mode_nxt     = abae_pkg::MODE_IDLE;
              res0         = mk_finish(held_len_r, abae_pkg::ST_SEND_DONE);
            end else begin
              res0     = retry_res;
              do_retry = 1'b1;
            end
          end else if (in_frame_type == data_code_r) begin
            res0     = mk_ack(in_frame_seqno[0]);
            res1     = retry_res;
            res_two  = 1'b1;
            do_retry = 1'b1;
            if (!pend_valid_r) begin
              pend_valid_nxt = 1'b1;
              pend_seq_nxt   = in_frame_seqno;
              pend_len_nxt   = plen;
            end
          end else begin
            res0     = retry_res;
            do_retry = 1'b1;
          end
        end else if (mode_r == abae_pkg::MODE_RECV && op == abae_pkg::OP_FRAME &&
                     !short_frame && in_frame_mbz == '0) begin
          if (in_frame_type == reset_code_r) begin
            res_any  = 1'b1;
            mode_nxt = abae_pkg::MODE_IDLE;
            res0     = mk_finish('0, abae_pkg::ST_PEER_QUIT);
          end else if (in_frame_type == data_code_r) begin
            res_any = 1'b1;
            res0    = mk_ack(in_frame_seqno[0]);
            if (in_frame_seqno == {7'd0, expect_bit_r}) begin
              res_two        = 1'b1;
              res1           = mk_finish((plen < recv_limit_r) ? plen : recv_limit_r,
                                         abae_pkg::ST_DELIVERED);
              expect_bit_nxt = ~expect_bit_r;
              mode_nxt       = abae_pkg::MODE_IDLE;
            end
          end
        end
      end
    endcase

    if (do_retry) begin
      if (retry_ok) begin
        att_nxt = att_r + abae_pkg::ATT_W'(1);
      end else begin
        mode_nxt = abae_pkg::MODE_IDLE;
      end
    end
  end

  assign q_push          = accept & res_any;
  assign q_push_job.res0 = res0;
  assign q_push_job.res1 = res1;
  assign q_push_job.two  = res_two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_att_r    <= abae_pkg::ATT_W'(5);
      data_code_r  <= abae_pkg::CODE_W'(0);
      ack_code_r   <= abae_pkg::CODE_W'(1);
      reset_code_r <= abae_pkg::CODE_W'(2);
    end else if (cfg_wr_en) begin
      case (abae_pkg::cfg_idx_t'(cfg_index))
        abae_pkg::CFG_MAX_ATTEMPTS: max_att_r    <= cfg_wdata[abae_pkg::ATT_W-1:0];
        abae_pkg::CFG_DATA_TYPE:    data_code_r  <= cfg_wdata;
        abae_pkg::CFG_ACK_TYPE:     ack_code_r   <= cfg_wdata;
        abae_pkg::CFG_RESET_TYPE:   reset_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_bit_r   <= 1'b0;
      expect_bit_r <= 1'b0;
      mode_r       <= abae_pkg::MODE_IDLE;
      att_r        <= '0;
      held_len_r   <= '0;
      recv_limit_r <= '0;
      pend_valid_r <= 1'b0;
      pend_seq_r   <= '0;
      pend_len_r   <= '0;
    end else if (accept) begin
      send_bit_r   <= send_bit_nxt;
      expect_bit_r <= expect_bit_nxt;
      mode_r       <= mode_nxt;
      att_r        <= att_nxt;
      held_len_r   <= held_len_nxt;
      recv_limit_r <= recv_limit_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_seq_r   <= pend_seq_nxt;
      pend_len_r   <= pend_len_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/abae_queue.sv =====
`default_nettype none
module abae_queue #(
  parameter int DEPTH = abae_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire abae_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output abae_pkg::job_t      pop_job,
  output logic                empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastSlot = PTR_W'(DEPTH - 1);

  abae_pkg::job_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastSlot) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastSlot) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/abae_back.sv =====
`default_nettype none
module abae_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire abae_pkg::job_t              q_pop_job,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_action,
  output logic                             out_seqno,
  output logic                             out_ackno,
  output logic [abae_pkg::LEN_W-1:0]       out_len,
  output logic [2:0]                       out_status,
  output logic                             out_last
);

  logic              valid_r, valid_nxt;
  logic              second_r, second_nxt;
  abae_pkg::result_t res_r, res_nxt;
  logic              last_r, last_nxt;
  abae_pkg::result_t second_res_r, second_res_nxt;
  logic              load;

  // output slot frees when empty or when its transaction completes
  assign load = ~valid_r | out_ready;

  always_comb begin
    valid_nxt      = valid_r;
    second_nxt     = second_r;
    res_nxt        = res_r;
    last_nxt       = last_r;
    second_res_nxt = second_res_r;
    q_pop          = 1'b0;
    if (load) begin
      if (second_r) begin
        valid_nxt  = 1'b1;
        res_nxt    = second_res_r;
        last_nxt   = 1'b1;
        second_nxt = 1'b0;
      end else if (!q_empty) begin
        q_pop          = 1'b1;
        valid_nxt      = 1'b1;
        res_nxt        = q_pop_job.res0;
        last_nxt       = ~q_pop_job.two;
        second_nxt     = q_pop_job.two;
        second_res_nxt = q_pop_job.res1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r        <= res_nxt;
    last_r       <= last_nxt;
    second_res_r <= second_res_nxt;
  end

  assign out_valid  = valid_r;
  assign out_action = res_r.action;
  assign out_seqno  = res_r.seqno;
  assign out_ackno  = res_r.ackno;
  assign out_len    = res_r.len;
  assign out_status = res_r.status;
  assign out_last   = last_r;

endmodule
`default_nettype wire

// ===== src/alternating_bit_arq_engine.sv =====
`default_nettype none
// Stop-and-wait alternating-bit link controller. Each event (send request,
// receive request, arrived frame header, timeout) is accepted while the
// job queue has room, and is turned at once into zero, one or two results
// (transmit data frame, transmit ack, finish call); the protocol state moves on
// at acceptance, so events may arrive back to back. Results leave through a
// registered output, one per cycle while out_ready is high, after passing
// through the job queue slot and the output register; an event with two
// results holds the output for both, and the output serialiser limits the
// sustained event rate. The configuration registers are to be written only
// while no results are in flight.
module alternating_bit_arq_engine #(
  parameter int QUEUE_DEPTH = abae_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [abae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [abae_pkg::CODE_W-1:0]     cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_operation,
  input  wire logic [abae_pkg::LEN_W-1:0]      in_request_len,
  input  wire logic [7:0]                      in_frame_type,
  input  wire logic [7:0]                      in_frame_seqno,
  input  wire logic [7:0]                      in_frame_ackno,
  input  wire logic [7:0]                      in_frame_mbz,
  input  wire logic [abae_pkg::FLEN_W-1:0]     in_frame_len,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_action,
  output logic                                 out_seqno,
  output logic                                 out_ackno,
  output logic [abae_pkg::LEN_W-1:0]           out_len,
  output logic [2:0]                           out_status,
  output logic                                 out_last
);

  logic           q_full, q_empty, q_push, q_pop;
  abae_pkg::job_t q_push_job, q_pop_job;

  abae_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_request_len (in_request_len),
    .in_frame_type  (in_frame_type),
    .in_frame_seqno (in_frame_seqno),
    .in_frame_ackno (in_frame_ackno),
    .in_frame_mbz   (in_frame_mbz),
    .in_frame_len   (in_frame_len),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_job     (q_push_job)
  );

  abae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty)
  );

  abae_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop_job  (q_pop_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_action (out_action),
    .out_seqno  (out_seqno),
    .out_ackno  (out_ackno),
    .out_len    (out_len),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

// ===== bench/tb_alternating_bit_arq_engine.sv =====
`default_nettype none
module tb_alternating_bit_arq_engine;
  import abae_pkg::*;

  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  req;
    logic [7:0]        ftype;
    logic [7:0]        fseq;
    logic [7:0]        fack;
    logic [7:0]        fmbz;
    logic [FLEN_W-1:0] flen;
  } link_ev_t;

  typedef struct packed {
    action_t          action;
    logic             seqno;
    logic             ackno;
    logic [LEN_W-1:0] len;
    status_t          status;
    logic             last;
  } link_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CODE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_operation;
  logic [LEN_W-1:0]     in_request_len;
  logic [7:0]           in_frame_type;
  logic [7:0]           in_frame_seqno;
  logic [7:0]           in_frame_ackno;
  logic [7:0]           in_frame_mbz;
  logic [FLEN_W-1:0]    in_frame_len;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_action;
  logic                 out_seqno;
  logic                 out_ackno;
  logic [LEN_W-1:0]     out_len;
  logic [2:0]           out_status;
  logic                 out_last;

  alternating_bit_arq_engine u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_request_len (in_request_len),
    .in_frame_type  (in_frame_type),
    .in_frame_seqno (in_frame_seqno),
    .in_frame_ackno (in_frame_ackno),
    .in_frame_mbz   (in_frame_mbz),
    .in_frame_len   (in_frame_len),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_seqno      (out_seqno),
    .out_ackno      (out_ackno),
    .out_len        (out_len),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  // predicted link state and register copies
  logic             p_send_bit;
  logic             p_expect_bit;
  mode_t            p_mode;
  logic [ATT_W-1:0] p_attempts;
  logic [LEN_W-1:0] p_held_len;
  logic [LEN_W-1:0] p_recv_limit;
  logic             p_pend_valid;
  logic [7:0]       p_pend_seq;
  logic [LEN_W-1:0] p_pend_len;
  logic [ATT_W-1:0] r_max_att;
  logic [7:0]       r_data_type;
  logic [7:0]       r_ack_type;
  logic [7:0]       r_reset_type;

  link_res_t expected_q[$];
  int        pushed_total = 0;
  int        events_sent = 0;
  int        results_checked = 0;
  int        settings_run = 0;
  int        errors = 0;
  bit        quiet = 0;
  int        gap_pct = 20;
  int        stall_pct = 20;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 500000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int min_int(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  task automatic push_res(input action_t act, input logic sq, input logic ak, input int len,
                          input status_t st, input logic last);
    link_res_t r;
    r.action = act;
    r.seqno  = sq;
    r.ackno  = ak;
    r.len    = LEN_W'(len);
    r.status = st;
    r.last   = last;
    expected_q.push_back(r);
    pushed_total++;
  endtask

  task automatic resend_or_fail();
    if (p_attempts < r_max_att) begin
      p_attempts = p_attempts + ATT_W'(1);
      push_res(ACT_DATA, p_send_bit, 1'b0, p_held_len, ST_NONE, 1'b1);
    end else begin
      p_mode = MODE_IDLE;
      push_res(ACT_FINISH, 1'b0, 1'b0, 0, ST_SEND_FAILED, 1'b1);
    end
  endtask

  // advances the link state by one accepted transaction
  task automatic predict_event(input link_ev_t ev);
    int pay;
    pay = 0;
    if (ev.flen >= HEADER_BYTES) pay = min_int(int'(ev.flen) - HEADER_BYTES, MAX_PAYLOAD);
    case (ev.op)
      OP_SEND: if (p_mode == MODE_IDLE) begin
        if (ev.req == 0) begin
          push_res(ACT_FINISH, 1'b0, 1'b0, 0, ST_SEND_FAILED, 1'b1);
        end else begin
          p_held_len = LEN_W'(min_int(ev.req, MAX_PAYLOAD));
          p_attempts = ATT_W'(1);
          p_mode     = MODE_SEND;
          push_res(ACT_DATA, p_send_bit, 1'b0, p_held_len, ST_NONE, 1'b1);
        end
      end
      OP_RECV: if (p_mode == MODE_IDLE) begin
        if (ev.req == 0) begin
          push_res(ACT_FINISH, 1'b0, 1'b0, 0, ST_NONE, 1'b1);
        end else begin
          p_recv_limit = ev.req;
          if (p_pend_valid) begin
            p_pend_valid = 1'b0;
            if (p_pend_seq == {7'b0, p_expect_bit}) begin
              push_res(ACT_ACK, 1'b0, ~p_pend_seq[0], 0, ST_NONE, 1'b0);
              push_res(ACT_FINISH, 1'b0, 1'b0, min_int(p_pend_len, ev.req), ST_DELIVERED, 1'b1);
              p_expect_bit = ~p_expect_bit;
            end else begin
              p_mode = MODE_RECV;
              push_res(ACT_ACK, 1'b0, ~p_pend_seq[0], 0, ST_NONE, 1'b1);
            end
          end else begin
            p_mode = MODE_RECV;
          end
        end
      end
      default: if (p_mode == MODE_SEND) begin
        if (ev.op == OP_TIMEOUT || ev.flen < HEADER_BYTES) begin
          resend_or_fail();
        end else if (ev.ftype == r_reset_type) begin
          p_mode = MODE_IDLE;
          push_res(ACT_FINISH, 1'b0, 1'b0, 0, ST_PEER_QUIT, 1'b1);
        end else if (ev.ftype == r_ack_type) begin
          if (ev.fack == {7'b0, ~p_send_bit}) begin
            p_send_bit = ~p_send_bit;
            p_mode     = MODE_IDLE;
            push_res(ACT_FINISH, 1'b0, 1'b0, p_held_len, ST_SEND_DONE, 1'b1);
          end else begin
            resend_or_fail();
          end
        end else if (ev.ftype == r_data_type) begin
          push_res(ACT_ACK, 1'b0, ~ev.fseq[0], 0, ST_NONE, 1'b0);
          if (!p_pend_valid) begin
            p_pend_valid = 1'b1;
            p_pend_seq   = ev.fseq;
            p_pend_len   = LEN_W'(pay);
          end
          resend_or_fail();
        end else begin
          resend_or_fail();
        end
      end else if (p_mode == MODE_RECV && ev.op == OP_FRAME && ev.flen >= HEADER_BYTES &&
                   ev.fmbz == 0) begin
        if (ev.ftype == r_reset_type) begin
          p_mode = MODE_IDLE;
          push_res(ACT_FINISH, 1'b0, 1'b0, 0, ST_PEER_QUIT, 1'b1);
        end else if (ev.ftype == r_data_type) begin
          if (ev.fseq == {7'b0, p_expect_bit}) begin
            push_res(ACT_ACK, 1'b0, ~ev.fseq[0], 0, ST_NONE, 1'b0);
            push_res(ACT_FINISH, 1'b0, 1'b0, min_int(pay, p_recv_limit), ST_DELIVERED, 1'b1);
            p_expect_bit = ~p_expect_bit;
            p_mode       = MODE_IDLE;
          end else begin
            push_res(ACT_ACK, 1'b0, ~ev.fseq[0], 0, ST_NONE, 1'b1);
          end
        end
      end
    endcase
  endtask

  function automatic link_ev_t mk(input op_t op, input int req, input int ftype, input int fseq,
                                  input int fack, input int fmbz, input int flen);
    link_ev_t ev;
    ev.op    = op;
    ev.req   = LEN_W'(req);
    ev.ftype = 8'(ftype);
    ev.fseq  = 8'(fseq);
    ev.fack  = 8'(fack);
    ev.fmbz  = 8'(fmbz);
    ev.flen  = FLEN_W'(flen);
    return ev;
  endfunction

  function automatic logic [LEN_W-1:0] rand_req();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return LEN_W'($urandom_range(MAX_PAYLOAD - 3, 1023));
    if (pick < 8) return LEN_W'($urandom_range(1, 16));
    return LEN_W'($urandom_range(1, MAX_PAYLOAD));
  endfunction

  function automatic logic [FLEN_W-1:0] rand_flen();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return FLEN_W'($urandom_range(0, HEADER_BYTES - 1));
    if (pick == 1) return FLEN_W'(1024);
    if (pick < 8) return FLEN_W'($urandom_range(HEADER_BYTES, 24));
    return FLEN_W'($urandom_range(HEADER_BYTES, 1024));
  endfunction

  function automatic logic [7:0] unknown_type();
    logic [7:0] t;
    t = 8'($urandom);
    while (t == r_data_type || t == r_ack_type || t == r_reset_type) t = 8'($urandom);
    return t;
  endfunction

  // mostly protocol-correct traffic for the current mode, with some noise
  function automatic link_ev_t make_event(input bit lossy);
    link_ev_t ev;
    int       pick;
    int       sel;
    ev.op    = OP_FRAME;
    ev.req   = rand_req();
    ev.ftype = r_data_type;
    ev.fseq  = 8'($urandom_range(0, 1));
    ev.fack  = 8'($urandom_range(0, 1));
    ev.fmbz  = 8'h00;
    ev.flen  = rand_flen();
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    if (p_mode == MODE_IDLE) begin
      if (pick < 45) ev.op = OP_SEND;
      else if (pick < 85) ev.op = OP_RECV;
      else sel = 9;
    end else if (p_mode == MODE_SEND) begin
      if (pick < (lossy ? 3 : 30)) begin
        ev.ftype = r_ack_type;
        ev.fack  = {7'b0, ~p_send_bit};
        sel      = -1;
      end else if (lossy && sel == 5 && $urandom_range(0, 9) != 0) begin
        sel = 0;
      end
      case (sel)
        0, 1: ev.op = OP_TIMEOUT;
        2: begin
          ev.ftype = r_ack_type;
          ev.fack  = {7'($urandom_range(0, 127)), p_send_bit};
        end
        3, 4: begin
          ev.fmbz = 8'($urandom);
          if ($urandom_range(0, 3) == 0) ev.fseq = 8'($urandom);
        end
        5: ev.ftype = r_reset_type;
        6: begin
          ev.ftype = 8'($urandom);
          ev.flen  = FLEN_W'($urandom_range(0, HEADER_BYTES - 1));
        end
        7: ev.ftype = unknown_type();
        8: ev.op = op_t'($urandom_range(0, 1));
        default: ;
      endcase
    end else begin
      if (pick < 35) begin
        ev.fseq = {7'b0, p_expect_bit};
        sel     = -1;
      end
      case (sel)
        0, 1, 2: begin
          if ($urandom_range(0, 1) == 0) ev.fseq = {7'b0, ~p_expect_bit};
          else ev.fseq = {7'($urandom_range(1, 127)), 1'($urandom)};
        end
        3: ev.fmbz = 8'($urandom_range(1, 255));
        4: ev.ftype = r_reset_type;
        5: ev.flen = FLEN_W'($urandom_range(0, HEADER_BYTES - 1));
        6: ev.op = OP_TIMEOUT;
        7: ev.ftype = unknown_type();
        8: ev.op = op_t'($urandom_range(0, 1));
        default: ;
      endcase
    end
    if (sel == 9) begin
      ev.op    = op_t'($urandom_range(0, 3));
      ev.ftype = 8'($urandom);
      ev.fseq  = 8'($urandom);
      ev.fack  = 8'($urandom);
      ev.fmbz  = 8'($urandom);
      ev.flen  = FLEN_W'($urandom_range(0, 1024));
    end
    return ev;
  endfunction

  task automatic send_event(input link_ev_t ev);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= ev.op;
    in_request_len <= ev.req;
    in_frame_type  <= ev.ftype;
    in_frame_seqno <= ev.fseq;
    in_frame_ackno <= ev.fack;
    in_frame_mbz   <= ev.fmbz;
    in_frame_len   <= ev.flen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_event(ev);
    events_sent++;
  endtask

  // hold the sender off until every predicted result has come out
  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MAX_ATTEMPTS: r_max_att    = val[ATT_W-1:0];
      CFG_DATA_TYPE:    r_data_type  = val;
      CFG_ACK_TYPE:     r_ack_type   = val;
      CFG_RESET_TYPE:   r_reset_type = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(input int att, input int dt, input int at, input int rt,
                           input bit lossy, input int n);
    wait_drain();
    write_reg(CFG_MAX_ATTEMPTS, 8'(att));
    write_reg(CFG_DATA_TYPE, 8'(dt));
    write_reg(CFG_ACK_TYPE, 8'(at));
    write_reg(CFG_RESET_TYPE, 8'(rt));
    settings_run++;
    gap_pct   = 10 * $urandom_range(0, 4);
    stall_pct = 10 * $urandom_range(0, 4);
    repeat (n) send_event(make_event(lossy));
  endtask

  task automatic test_directed_cases();
    send_event(mk(OP_SEND, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
    send_event(mk(OP_RECV, 0, 0, 0, 0, 0, 0));
    send_event(mk(OP_TIMEOUT, 10'h3FF, 0, 0, 0, 0, 0));
    send_event(mk(OP_FRAME, 0, 0, 0, 0, 0, 100));
    send_event(mk(OP_SEND, 1023, 0, 0, 0, 0, 0));
    send_event(mk(OP_SEND, 5, 0, 0, 0, 0, 0));
    send_event(mk(OP_FRAME, 0, 1, 0, 1, 0, 3));
    send_event(mk(OP_FRAME, 0, 1, 0, 0, 0, 4));
    send_event(mk(OP_FRAME, 0, 8'hAA, 0, 0, 0, 20));
    send_event(mk(OP_FRAME, 0, 0, 1, 0, 8'hFF, 1024));
    send_event(mk(OP_TIMEOUT, 0, 0, 0, 0, 0, 0));
    send_event(mk(OP_SEND, 700, 0, 0, 0, 0, 0));
    send_event(mk(OP_FRAME, 0, 1, 0, 1, 0, 4));
    // held frame carries the wrong bit: acked and dropped
    send_event(mk(OP_RECV, 1020, 0, 0, 0, 0, 0));
    send_event(mk(OP_FRAME, 0, 0, 0, 0, 0, 1000));
    send_event(mk(OP_SEND, 10, 0, 0, 0, 0, 0));
    send_event(mk(OP_FRAME, 0, 0, 1, 0, 0, 50));
    send_event(mk(OP_FRAME, 0, 2, 0, 0, 0, 4));
    // held frame matches: delivered at once, clamped to the buffer
    send_event(mk(OP_RECV, 20, 0, 0, 0, 0, 0));
    send_event(mk(OP_RECV, 300, 0, 0, 0, 0, 0));
    send_event(mk(OP_SEND, 3, 0, 0, 0, 0, 0));
    send_event(mk(OP_TIMEOUT, 0, 0, 0, 0, 0, 0));
    send_event(mk(OP_FRAME, 0, 0, 0, 0, 0, 2));
    send_event(mk(OP_FRAME, 0, 0, 0, 0, 8'h80, 50));
    send_event(mk(OP_FRAME, 0, 0, 1, 0, 0, 50));
    send_event(mk(OP_FRAME, 0, 1, 0, 1, 0, 50));
    send_event(mk(OP_FRAME, 0, 2, 0, 0, 0, 4));
  endtask

  task automatic test_retry_limits();
    run_phase(0, 0, 1, 2, 1'b1, 120);
    run_phase(1, 0, 1, 2, 1'b1, 120);
    run_phase(15, 0, 1, 2, 1'b1, 120);
  endtask

  task automatic test_type_codes();
    run_phase(5, 8'hFF, 8'h00, 8'h80, 1'b0, 120);
    run_phase(3, 8'h55, 8'hAA, 8'h7F, 1'b0, 120);
    run_phase(4, 8'h07, 8'h07, 8'h09, 1'b0, 120);
    run_phase(2, 8'h11, 8'h22, 8'h11, 1'b0, 120);
  endtask

  task automatic test_random_traffic();
    repeat (5) begin
      run_phase($urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), 1'($urandom_range(0, 1)), 120);
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    run_phase(5, 0, 1, 2, 1'b0, 100);
  endtask

  // result sink with bursty back-pressure
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    link_res_t got;
    link_res_t want;
    if (rst_n && out_valid && out_ready) begin
      got.action = action_t'(out_action);
      got.seqno  = out_seqno;
      got.ackno  = out_ackno;
      got.len    = out_len;
      got.status = status_t'(out_status);
      got.last   = out_last;
      results_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("extra result at %0t: act %0d seq %0d ack %0d len %0d st %0d last %0d",
                   $time, got.action, got.seqno, got.ackno, got.len, got.status, got.last);
      end else begin
        want = expected_q.pop_front();
        if (got.action !== want.action || got.seqno !== want.seqno ||
            got.ackno !== want.ackno || got.len !== want.len ||
            got.status !== want.status || got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch %0t: want act %0d seq %0d ack %0d len %0d st %0d last %0d",
                     $time, want.action, want.seqno, want.ackno, want.len, want.status,
                     want.last);
            $display("              got  act %0d seq %0d ack %0d len %0d st %0d last %0d",
                     got.action, got.seqno, got.ackno, got.len, got.status, got.last);
          end
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_MAX_ATTEMPTS;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_operation   = OP_SEND;
    in_request_len = '0;
    in_frame_type  = '0;
    in_frame_seqno = '0;
    in_frame_ackno = '0;
    in_frame_mbz   = '0;
    in_frame_len   = '0;
    p_send_bit     = 1'b0;
    p_expect_bit   = 1'b0;
    p_mode         = MODE_IDLE;
    p_attempts     = '0;
    p_held_len     = '0;
    p_recv_limit   = '0;
    p_pend_valid   = 1'b0;
    p_pend_seq     = '0;
    p_pend_len     = '0;
    r_max_att      = 4'd5;
    r_data_type    = 8'd0;
    r_ack_type     = 8'd1;
    r_reset_type   = 8'd2;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_retry_limits();
    test_type_codes();
    test_random_traffic();
    test_back_to_back();
    wait_drain();
    // anything still outstanding never turned up
    errors += expected_q.size();

    $display("Run covered %0d link events and %0d checked results over %0d register settings",
             events_sent, results_checked, settings_run + 1);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
